// ===== hdl/eatrm_pkg.sv =====
// Shared types, constants and rounding helper for the Euler rotation block.
`default_nettype none
package eatrm_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int ENTRY_W  = 18;
  localparam int CORD_W   = 33;   // Q2.30 datapath plus sign and headroom
  localparam int TURN_W   = 32;   // angle scaled to 2^32 units per turn
  localparam int WIDE_W   = 40;
  localparam int PROD_W   = 2 * ENTRY_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int TAG_W    = 3;
  localparam int STEP_W   = $clog2(CORDIC_STEPS);
  localparam int ATAN_N   = 30;

  localparam logic signed [CORD_W-1:0] K_GAIN = CORD_W'(652032874);

  typedef logic signed [ENTRY_W-1:0] entry_t;

  localparam entry_t ONE_Q = entry_t'(1 << FRAC_BITS);

  // Arctangent of 2^-i in units of 2^32 per turn.
  localparam logic [29:0] ATAN_TBL [ATAN_N] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
    30'd20,        30'd10,        30'd5,         30'd3,        30'd1
  };

  typedef struct packed {
    logic             en;
    logic             second;  // second product of a sum
    logic [TAG_W-1:0] tag;
  } mac_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    entry_t           value;
  } mac_res_t;

  // Round to nearest (ties up) by sh bits, then clamp to +-1.0.
  function automatic entry_t rnd_sat(input logic signed [WIDE_W-1:0] v,
                                     input int unsigned sh);
    logic signed [WIDE_W-1:0] t;
    logic signed [WIDE_W-1:0] one;
    one = WIDE_W'(1) <<< FRAC_BITS;
    if (sh == 0) begin
      t = v;
    end else begin
      t = (v + (WIDE_W'(1) <<< (sh - 1))) >>> sh;
    end
    if (t > one) begin
      t = one;
    end else if (t < -one) begin
      t = -one;
    end
    return entry_t'(t);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/eatrm_cordic.sv =====
// Iterative CORDIC rotator: one micro-rotation per cycle, cosine and sine out.
`default_nettype none
module eatrm_cordic
  import eatrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output logic                       done,
  output entry_t                     cos_o,
  output entry_t                     sin_o
);

  localparam int ZSH = TURN_W - ANGLE_BITS;

  logic signed [CORD_W-1:0] x_r, y_r, z_r;
  logic signed [CORD_W-1:0] x_nxt, y_nxt, z_nxt;
  logic [STEP_W-1:0]        cnt_r;
  logic [1:0]               quad_r;
  logic                     busy_r;
  logic                     done_r;
  logic [TURN_W-1:0]        scaled;
  logic signed [CORD_W-1:0] dx, dy, at;
  entry_t                   c_q, s_q;

  assign scaled = TURN_W'(angle) << ZSH;

  always_comb begin
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    at = CORD_W'($signed({1'b0, ATAN_TBL[5'(cnt_r)]}));
    if (!z_r[CORD_W-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= K_GAIN;
        y_r    <= '0;
        z_r    <= CORD_W'(scaled[TURN_W-3:0]);
        quad_r <= scaled[TURN_W-1:TURN_W-2];
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign c_q = rnd_sat(WIDE_W'(x_r), 30 - FRAC_BITS);
  assign s_q = rnd_sat(WIDE_W'(y_r), 30 - FRAC_BITS);

  // Fold the quadrant back in.
  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_o = c_q;
        sin_o = s_q;
      end
      2'd1: begin
        cos_o = -s_q;
        sin_o = c_q;
      end
      2'd2: begin
        cos_o = -c_q;
        sin_o = -s_q;
      end
      default: begin
        cos_o = s_q;
        sin_o = -c_q;
      end
    endcase
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ===== hdl/eatrm_mac.sv =====
// Shared multiplier with a two-term accumulator, rounding and saturation.
`default_nettype none
module eatrm_mac
  import eatrm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mac_ctl_t ctl,
  input  wire entry_t   a,
  input  wire entry_t   b,
  output mac_res_t      res
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [SUM_W-1:0]  sum;
  mac_ctl_t                 stg_r;
  mac_res_t                 res_r;

  assign sum = SUM_W'(acc_r) + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.en    <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      stg_r       <= ctl;
      res_r.valid <= stg_r.en && stg_r.second;
    end
    prod_r <= a * b;
    if (stg_r.en && !stg_r.second) begin
      acc_r <= prod_r;
    end
    if (stg_r.en && stg_r.second) begin
      res_r.tag   <= stg_r.tag;
      res_r.value <= rnd_sat(WIDE_W'(sum), FRAC_BITS);
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== hdl/euler_angles_to_rotation_matrix_top.sv =====
// Top level: composes a rotation matrix from a sequence of axis rotations.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   angle, axis_code, last_angle
//   out_     output     out_valid / out_stall m00..m22, bad_axis
//
// A valid item runs 16 CORDIC micro-rotations, then 12
// products through the single multiplier plus its two-stage drain.
// An item with an invalid axis skips the rotation and goes straight to the finish state.
// Reset loads the identity matrix and clears the error flag.
// The result sits in an output register; a stalled result holds the block
// only when the next sequence end arrives before it is taken.
`default_nettype none
module euler_angles_to_rotation_matrix_top
  import eatrm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_angle,
  input  wire logic [1:0]  in_axis_code,
  input  wire logic        in_last_angle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output entry_t           out_m00,
  output entry_t           out_m01,
  output entry_t           out_m02,
  output entry_t           out_m10,
  output entry_t           out_m11,
  output entry_t           out_m12,
  output entry_t           out_m20,
  output entry_t           out_m21,
  output entry_t           out_m22,
  output logic             out_bad_axis
);

  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] AXIS_BAD = 2'd3;
  localparam logic [TAG_W-1:0] TAG_LAST = TAG_W'(5);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t     state_r;
  entry_t     m_r [9];
  entry_t     c_r, s_r;
  logic       err_r;
  logic       last_r;
  logic [1:0] p_r, q_r;
  logic [3:0] k_r;
  logic       out_valid_r;
  entry_t     out_m_r [9];
  logic       out_bad_r;

  logic       accept;
  logic       emit;
  logic       cord_start;
  logic       cord_done;
  entry_t     cord_c, cord_s;
  mac_ctl_t   mctl;
  mac_res_t   mres;
  entry_t     op_a, op_b;
  logic [3:0] rd_idx;
  logic [3:0] wr_idx;
  logic [1:0] rd_row, wr_row;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign cord_start = accept && (in_axis_code != AXIS_BAD);
  assign emit       = (state_r == ST_FINISH) && last_r && (!out_valid_r || !out_stall);

  eatrm_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .angle (in_angle[ANGLE_BITS-1:0]),
    .done  (cord_done),
    .cos_o (cord_c),
    .sin_o (cord_s)
  );

  // Issue order: k = {row, out_sel, term}. out p = Mp*c + Mq*s,
  // out q = Mp*(-s) + Mq*c.
  always_comb begin
    rd_row = k_r[3:2];
    rd_idx = {rd_row, 2'b00} - {2'b00, rd_row} + {2'b00, (k_r[0] ? q_r : p_r)};
    op_a   = m_r[rd_idx];
    case ({k_r[1], k_r[0]})
      2'b00:   op_b = c_r;
      2'b01:   op_b = s_r;
      2'b10:   op_b = -s_r;
      default: op_b = c_r;
    endcase
    mctl.en     = (state_r == ST_MUL);
    mctl.second = k_r[0];
    mctl.tag    = k_r[3:1];
  end

  eatrm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .a     (op_a),
    .b     (op_b),
    .res   (mres)
  );

  always_comb begin
    wr_row = mres.tag[2:1];
    wr_idx = {wr_row, 2'b00} - {2'b00, wr_row} + {2'b00, (mres.tag[0] ? q_r : p_r)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q : '0;
      end
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (mres.valid) begin
        m_r[wr_idx] <= mres.value;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            last_r <= in_last_angle;
            k_r    <= '0;
            unique case (in_axis_code) inside
              AXIS_X: begin
                p_r <= 2'd1;
                q_r <= 2'd2;
              end
              AXIS_Y: begin
                p_r <= 2'd2;
                q_r <= 2'd0;
              end
              AXIS_Z, AXIS_BAD: begin
                p_r <= 2'd0;
                q_r <= 2'd1;
              end
            endcase
            if (in_axis_code == AXIS_BAD) begin
              err_r   <= 1'b1;
              state_r <= ST_FINISH;
            end else begin
              state_r <= ST_ROT;
            end
          end
        end
        ST_ROT: begin
          if (cord_done) begin
            c_r     <= cord_c;
            s_r     <= cord_s;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          k_r <= k_r + 1'b1;
          if (k_r == 4'd11) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mres.valid && mres.tag == TAG_LAST) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (emit) begin
            // Emit the word and start the next sequence from identity.
            out_bad_r <= err_r;
            err_r     <= 1'b0;
            for (int i = 0; i < 9; i++) begin
              out_m_r[i] <= m_r[i];
              m_r[i]     <= (i == 0 || i == 4 || i == 8) ? ONE_Q : '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_bad_axis = out_bad_r;
  assign out_m00      = out_m_r[0];
  assign out_m01      = out_m_r[1];
  assign out_m02      = out_m_r[2];
  assign out_m10      = out_m_r[3];
  assign out_m11      = out_m_r[4];
  assign out_m12      = out_m_r[5];
  assign out_m20      = out_m_r[6];
  assign out_m21      = out_m_r[7];
  assign out_m22      = out_m_r[8];

endmodule
`default_nettype wire

// ===== test/tb_euler_angles_to_rotation_matrix_top.sv =====
// Testbench for the Euler angle rotation block: directed and random sequences checked against a predictor.
`timescale 1ns / 1ps
module tb_euler_angles_to_rotation_matrix_top;
  import eatrm_pkg::*;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_e;

  typedef struct packed {
    logic [15:0] angle;
    axis_e       axis;
    logic        last;
  } angle_word_t;

  typedef struct packed {
    logic [8:0][ENTRY_W-1:0] m;   // row major, m[0] is m00
    logic                    bad;
  } matrix_word_t;

  localparam longint ONE_FIX = longint'(1) << FRAC_BITS;
  localparam longint CORDIC_X0 = 652032874;
  localparam longint ATAN_TURN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_angle = '0;
  logic [1:0]  in_axis_code = '0;
  logic        in_last_angle = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  entry_t      out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  entry_t      out_m20, out_m21, out_m22;
  logic        out_bad_axis;

  angle_word_t  angle_words [$];
  matrix_word_t matrix_expect [$];
  angle_word_t  cur_word;
  longint       run_mat [9];
  bit           axis_err;
  int unsigned  fail_count = 0;
  int unsigned  results_seen = 0;
  string        entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                   "m20", "m21", "m22"};

  // sender pacing
  int unsigned gap_left = 0;
  int unsigned tx_quiet_left = 0;
  bit          tx_quiet = 1'b0;
  // receiver pacing
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_quiet_left = 0;
  bit          rx_quiet = 1'b0;

  euler_angles_to_rotation_matrix_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_angle     (in_angle),
    .in_axis_code (in_axis_code),
    .in_last_angle(in_last_angle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_m00      (out_m00),
    .out_m01      (out_m01),
    .out_m02      (out_m02),
    .out_m10      (out_m10),
    .out_m11      (out_m11),
    .out_m12      (out_m12),
    .out_m20      (out_m20),
    .out_m21      (out_m21),
    .out_m22      (out_m22),
    .out_bad_axis (out_bad_axis)
  );

  always #5 clk = ~clk;

  // Round to nearest with ties up, then clamp to +-1.0.
  function automatic longint round_clamp(input longint v, input int sh);
    longint t;
    t = (sh == 0) ? v : ((v + (longint'(1) << (sh - 1))) >>> sh);
    if (t > ONE_FIX) t = ONE_FIX;
    else if (t < -ONE_FIX) t = -ONE_FIX;
    return t;
  endfunction

  function automatic void cordic_cos_sin(input logic [15:0] ang, output longint c,
                                         output longint s);
    logic [31:0] turn;
    longint      x, y, z, dx, dy, cq, sq;
    int          i;
    turn = {ang, 16'h0000};
    z = longint'({2'b00, turn[29:0]});
    x = CORDIC_X0;
    y = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    cq = round_clamp(x, 30 - FRAC_BITS);
    sq = round_clamp(y, 30 - FRAC_BITS);
    // fold the quadrant back in
    case (turn[31:30])
      2'd0: begin c = cq;  s = sq;  end
      2'd1: begin c = -sq; s = cq;  end
      2'd2: begin c = -cq; s = -sq; end
      default: begin c = sq; s = -cq; end
    endcase
  endfunction

  function automatic void load_identity();
    int i;
    for (i = 0; i < 9; i++) run_mat[i] = (i % 4 == 0) ? ONE_FIX : 0;
    axis_err = 1'b0;
  endfunction

  // Right-multiply the running matrix by one axis rotation, or flag an invalid axis; queue the matrix on the last word.
  function automatic void apply_rotation(input angle_word_t w);
    longint       c, s, acc;
    longint       t [9];
    longint       r [9];
    int           i, j, k;
    matrix_word_t res;
    if (w.axis == AXIS_BAD) begin
      axis_err = 1'b1;
    end else begin
      cordic_cos_sin(w.angle, c, s);
      for (i = 0; i < 9; i++) t[i] = 0;
      case (w.axis)
        AXIS_X: begin
          t[0] = ONE_FIX; t[4] = c; t[5] = -s; t[7] = s; t[8] = c;
        end
        AXIS_Y: begin
          t[0] = c; t[2] = s; t[4] = ONE_FIX; t[6] = -s; t[8] = c;
        end
        default: begin
          t[0] = c; t[1] = -s; t[3] = s; t[4] = c; t[8] = ONE_FIX;
        end
      endcase
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          acc = 0;
          for (k = 0; k < 3; k++) acc += run_mat[i * 3 + k] * t[k * 3 + j];
          r[i * 3 + j] = round_clamp(acc, FRAC_BITS);
        end
      end
      for (i = 0; i < 9; i++) run_mat[i] = r[i];
    end
    if (w.last) begin
      for (i = 0; i < 9; i++) res.m[i] = ENTRY_W'(run_mat[i]);
      res.bad = axis_err;
      matrix_expect.push_back(res);
      load_identity();
    end
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 16);
    else return $urandom_range(40, 120);
  endfunction

  function automatic void add_word(input logic [15:0] ang, input axis_e ax, input bit last);
    angle_word_t w;
    w.angle = ang;
    w.axis  = ax;
    w.last  = last;
    angle_words.push_back(w);
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] a;
    case ($urandom_range(0, 7))
      0: a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: a = {2'($urandom_range(0, 3)), 14'h0000} + 16'($urandom_range(0, 2)) - 16'd1;
      default: a = 16'($urandom_range(0, 65535));
    endcase
    return a;
  endfunction

  function automatic void check_result();
    matrix_word_t got, want;
    int           i;
    got.m   = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10,
               out_m02, out_m01, out_m00};
    got.bad = out_bad_axis;
    results_seen++;
    if (matrix_expect.size() == 0) begin
      $error("result word with no expectation pending");
      fail_count++;
    end else begin
      want = matrix_expect.pop_front();
      for (i = 0; i < 9; i++) begin
        if (got.m[i] !== want.m[i]) begin
          $error("%s expected %0d actual %0d", entry_name[i],
                 $signed(want.m[i]), $signed(got.m[i]));
          fail_count++;
        end
      end
      if (got.bad !== want.bad) begin
        $error("bad_axis expected %0b actual %0b", want.bad, got.bad);
        fail_count++;
      end
    end
  endfunction

  // Driver: present queued words, advance on acceptance, insert random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) apply_rotation(cur_word);
      if (tx_quiet_left == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        tx_quiet_left = $urandom_range(20, 150);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (angle_words.size() > 0) begin
        cur_word = angle_words.pop_front();
        in_angle      <= cur_word.angle;
        in_axis_code  <= cur_word.axis;
        in_last_angle <= cur_word.last;
        in_valid      <= 1'b1;
        tx_quiet_left--;
        gap_left = tx_quiet ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check accepted results and drive random stalls, with two long holds.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
        if (results_seen == 60 || results_seen == 300) hold_left = 600;
      end
      if (rx_quiet_left == 0) begin
        rx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet_left = $urandom_range(30, 300);
      end
      rx_quiet_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!rx_quiet && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic wait_drained();
    while (angle_words.size() != 0 || in_valid || matrix_expect.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_random(input int unsigned target);
    int unsigned n, len, i;
    bit          broken;
    axis_e       ax;
    n = 0;
    while (n < target) begin
      // mostly short sequences, now and then a long one to pile up rounding
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 5);
      broken = ($urandom_range(0, 9) == 0);
      for (i = 0; i < len; i++) begin
        ax = axis_e'($urandom_range(0, 2));
        if (broken && $urandom_range(0, 2) == 0) ax = AXIS_BAD;
        add_word(pick_angle(), ax, i == len - 1);
      end
      n += len;
    end
  endtask

  initial begin
    load_identity();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single-word sequences at the quadrant edges and an invalid axis alone
    add_word(16'h0000, AXIS_X, 1'b1);
    add_word(16'hFFFF, AXIS_Z, 1'b1);
    add_word(16'h4000, AXIS_Y, 1'b1);
    add_word(16'h8000, AXIS_X, 1'b1);
    add_word(16'hC000, AXIS_Z, 1'b1);
    add_word(16'h1234, AXIS_BAD, 1'b1);
    // plain three-axis sequence
    add_word(16'h2000, AXIS_X, 1'b0);
    add_word(16'h1000, AXIS_Y, 1'b0);
    add_word(16'h6000, AXIS_Z, 1'b1);
    // invalid axis first: flag must stick to the end of the sequence
    add_word(16'h1234, AXIS_BAD, 1'b0);
    add_word(16'h5555, AXIS_Z, 1'b0);
    add_word(16'hAAAA, AXIS_Y, 1'b1);
    // flag cleared after the result
    add_word(16'h0100, AXIS_X, 1'b1);
    add_word(16'h7FFF, AXIS_Y, 1'b0);
    add_word(16'h8001, AXIS_Y, 1'b1);
    add_word(16'h3FFF, AXIS_Z, 1'b0);
    add_word(16'hBFFF, AXIS_X, 1'b1);
    add_word(16'h0001, AXIS_Z, 1'b0);
    add_word(16'hFFFE, AXIS_Y, 1'b0);
    add_word(16'h2AAA, AXIS_X, 1'b1);
    // invalid axis on the last word of a longer sequence
    add_word(16'h5A5A, AXIS_Z, 1'b0);
    add_word(16'hA5A5, AXIS_BAD, 1'b1);
    wait_drained();

    push_random(750);
    wait_drained();
    push_random(750);
    wait_drained();

    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_euler_angles_to_rotation_matrix_top: clean");
    end else begin
      $display("tb_euler_angles_to_rotation_matrix_top: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_euler_angles_to_rotation_matrix_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/eatrm_pkg.sv
hdl/eatrm_cordic.sv
hdl/eatrm_mac.sv
hdl/euler_angles_to_rotation_matrix_top.sv
test/tb_euler_angles_to_rotation_matrix_top.sv
